FILE: rtl/bls_pkg.sv
// bls_pkg: item types, request and status codes, and cell control for the
// bounded lifo stack. No dependencies; used by bls_cell and the top level.
package bls_pkg;

  // request codes
  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP  = 2'd1;
  localparam logic [1:0] CMD_PEEK = 2'd2;
  localparam logic [1:0] CMD_LIST = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  // cell operations
  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_PUSH = 2'd1;
  localparam logic [1:0] OP_POP  = 2'd2;
  localparam logic [1:0] OP_ROT  = 2'd3;

  localparam int WORD_W  = 32;
  localparam int COUNT_W = 5;

  typedef struct packed {
    logic [1:0]               cmd;
    logic signed [WORD_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [WORD_W-1:0] element;
    logic [COUNT_W-1:0]       fill_count;
    logic                     is_empty;
    logic                     is_full;
    logic                     last;
  } out_item_t;

  typedef struct packed {
    logic [1:0] op;
    logic       tail;
  } cell_ctrl_t;

endpackage

FILE: rtl/bls_cell.sv
// bls_cell: one slot of the stack chain, shifting its word to or from its
// neighbors. Depends on bls_pkg for the cell control struct and op codes.
module bls_cell (
  input  logic                            clk,
  input  bls_pkg::cell_ctrl_t             ctrl,
  input  logic signed [bls_pkg::WORD_W-1:0] left_word,
  input  logic signed [bls_pkg::WORD_W-1:0] right_word,
  input  logic signed [bls_pkg::WORD_W-1:0] head_word,
  output logic signed [bls_pkg::WORD_W-1:0] word
);
  import bls_pkg::*;

  logic signed [WORD_W-1:0] word_r;
  logic signed [WORD_W-1:0] word_nxt;

  // push shifts toward the bottom, pop toward the top, rotate wraps the head
  // word into the deepest occupied slot
  always_comb begin
    unique case (ctrl.op)
      OP_HOLD: word_nxt = word_r;
      OP_PUSH: word_nxt = left_word;
      OP_POP:  word_nxt = right_word;
      OP_ROT:  word_nxt = ctrl.tail ? head_word : right_word;
    endcase
  end

  // payload register, no reset
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

FILE: rtl/bounded_lifo_stack_core.sv
// bounded_lifo_stack_core: top level of the bounded lifo stack, a chain of
// DEPTH word cells with a fill counter and a registered result stage.
// Depends on bls_pkg and bls_cell.
//
// A stack of up to DEPTH signed 32-bit words held in a row of cells, the top
// word in the first cell outside a list walk. Push, pop and peek each give
// one result, so such items are taken one per cycle while the result register
// drains. A list request on a stack of n words gives n results, top first, by
// rotating the chain one cell per cycle while the result register drains, so
// that the contents are back in place after the last word; no item is
// accepted until the list is done. A list on an empty stack gives one result
// with status empty. fill_count carries the low five bits of the word count.
module bounded_lifo_stack_core #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bls_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output bls_pkg::out_item_t out_item
);
  import bls_pkg::*;

  localparam int FW = $clog2(DEPTH + 1);

  logic [FW-1:0]            fill_r, fill_nxt;
  logic [FW-1:0]            cnt_r, cnt_nxt;
  logic                     listing_r, listing_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_item_r, out_item_nxt;
  logic [1:0]               cell_op;
  logic                     in_accept;
  logic                     out_free;
  logic                     is_full_now;
  logic                     is_empty_now;
  logic                     emit;
  logic [1:0]               res_status;
  logic signed [WORD_W-1:0] res_element;
  logic signed [WORD_W-1:0] words [0:DEPTH];
  cell_ctrl_t               ctrl [0:DEPTH-1];

  // handshake
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = listing_r || !out_free;
  assign in_accept = in_valid && !in_stall;

  assign is_full_now  = (fill_r == FW'(DEPTH));
  assign is_empty_now = (fill_r == '0);

  // request decode and result build
  always_comb begin
    fill_nxt      = fill_r;
    cnt_nxt       = cnt_r;
    listing_nxt   = listing_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    cell_op       = OP_HOLD;
    emit          = 1'b0;
    res_status    = ST_OK;
    res_element   = '0;

    if (listing_r && out_free) begin
      // list walk: show head word, rotate chain
      cell_op                 = OP_ROT;
      cnt_nxt                 = cnt_r - FW'(1);
      out_valid_nxt           = 1'b1;
      out_item_nxt.status     = ST_OK;
      out_item_nxt.element    = words[0];
      out_item_nxt.fill_count = COUNT_W'(fill_r);
      out_item_nxt.is_empty   = is_empty_now;
      out_item_nxt.is_full    = is_full_now;
      out_item_nxt.last       = (cnt_r == FW'(1));
      if (cnt_r == FW'(1)) begin
        listing_nxt = 1'b0;
      end
    end else if (in_accept) begin
      case (in_item.cmd)
        CMD_PUSH: begin
          emit = 1'b1;
          if (is_full_now) begin
            res_status  = ST_OVERFLOW;
            res_element = words[0];
          end else begin
            cell_op     = OP_PUSH;
            fill_nxt    = fill_r + FW'(1);
            res_element = in_item.push_value;
          end
        end
        CMD_POP: begin
          emit = 1'b1;
          if (is_empty_now) begin
            res_status = ST_UNDERFLOW;
          end else begin
            cell_op     = OP_POP;
            fill_nxt    = fill_r - FW'(1);
            res_element = (fill_r >= FW'(2)) ? words[1] : '0;
          end
        end
        CMD_PEEK: begin
          emit = 1'b1;
          if (is_empty_now) begin
            res_status = ST_EMPTY;
          end else begin
            res_element = words[0];
          end
        end
        default: begin
          if (is_empty_now) begin
            emit       = 1'b1;
            res_status = ST_EMPTY;
          end else begin
            listing_nxt = 1'b1;
            cnt_nxt     = fill_r;
          end
        end
      endcase

      if (emit) begin
        out_valid_nxt           = 1'b1;
        out_item_nxt.status     = res_status;
        out_item_nxt.element    = res_element;
        out_item_nxt.fill_count = COUNT_W'(fill_nxt);
        out_item_nxt.is_empty   = (fill_nxt == '0);
        out_item_nxt.is_full    = (fill_nxt == FW'(DEPTH));
        out_item_nxt.last       = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      cnt_r       <= '0;
      listing_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      cnt_r       <= cnt_nxt;
      listing_r   <= listing_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload register
  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // chain end feeds zero on pop
  assign words[DEPTH] = '0;

  // cell chain, top of stack in cell 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign ctrl[i].op   = cell_op;
    assign ctrl[i].tail = (fill_r == FW'(i + 1));

    if (i == 0) begin : g_head
      bls_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl[i]),
        .left_word  (in_item.push_value),
        .right_word (words[i+1]),
        .head_word  (words[0]),
        .word       (words[i])
      );
    end else begin : g_body
      bls_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl[i]),
        .left_word  (words[i-1]),
        .right_word (words[i+1]),
        .head_word  (words[0]),
        .word       (words[i])
      );
    end
  end

  // count never passes capacity
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(DEPTH))
    else $error("fill count above capacity");

  // a list walk only runs over a non-empty stack with a count in range
  a_list_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    listing_r |-> (cnt_r != '0 && cnt_r <= fill_r))
    else $error("list counter out of range");

  // the fill count does not move during a list walk
  a_list_fill: assert property (@(posedge clk) disable iff (!rst_n)
    listing_r |=> (fill_r == $past(fill_r)))
    else $error("fill count changed during list");

  // no new item while a list walk is running
  a_list_block: assert property (@(posedge clk) disable iff (!rst_n)
    listing_r |-> !in_accept)
    else $error("item accepted during list");

endmodule
